### rtl/pid_pkg.sv
// Package: widths, constants and shared types of the PID servo controller.
package pid_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int INTEGRAL_BITS = 24;
  localparam int SETPOINT_BITS = 10;
  localparam int GAIN_BITS     = 12;
  localparam int DRIVE_BITS    = 10;
  localparam int SERVO_BITS    = 8;

  localparam int ERR_BITS  = ((SAMPLE_BITS > SETPOINT_BITS) ? SAMPLE_BITS : SETPOINT_BITS) + 1;
  localparam int DIFF_BITS = ERR_BITS + 1;
  localparam int INT_SHIFT = 6;
  localparam int ERR_SH_BITS = ERR_BITS - INT_SHIFT;
  localparam int OUT_SHIFT = 2;

  localparam int P_BITS = GAIN_BITS + 1 + ERR_BITS;
  localparam int D_BITS = GAIN_BITS + 1 + DIFF_BITS;
  localparam int I_BITS = GAIN_BITS + 1 + INTEGRAL_BITS;
  localparam int SUM_BITS =
    ((INTEGRAL_BITS > DIFF_BITS) ? INTEGRAL_BITS : DIFF_BITS) + GAIN_BITS + 3;

  localparam logic [DRIVE_BITS-1:0] DRIVE_MAX  = 10'd1023;
  localparam logic [SERVO_BITS-1:0] SERVO_BASE = 8'd50;

  // drive / 10 as (drive * 205) >> 11, exact for drive below 1029
  localparam int DIV_MUL_BITS = 8;
  localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = 8'd205;
  localparam int DIV_SHIFT = 11;
  localparam int QP_BITS   = DRIVE_BITS + DIV_MUL_BITS;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SETPOINT = 2'd0,
    REG_KP       = 2'd1,
    REG_KD       = 2'd2,
    REG_KI       = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] kp;
    logic [GAIN_BITS-1:0] kd;
    logic [GAIN_BITS-1:0] ki;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0]      error;
    logic signed [DIFF_BITS-1:0]     diff;
    logic signed [INTEGRAL_BITS-1:0] integral;
  } err_t;

  typedef struct packed {
    logic signed [P_BITS-1:0] p;
    logic signed [D_BITS-1:0] d;
    logic signed [I_BITS-1:0] i;
  } prod_t;

endpackage

### rtl/pid_err_stage.sv
// Input stage: error, saturating integral and error change; holds loop state.
module pid_err_stage import pid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic [SETPOINT_BITS-1:0] setpoint,
  output logic                     out_valid,
  input  logic                     out_ready,
  output err_t                     out_data
);

  localparam logic signed [INTEGRAL_BITS-1:0] ACC_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] ACC_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  logic signed [ERR_BITS-1:0]      error;
  logic signed [ERR_BITS-1:0]      last_error;
  logic signed [ERR_SH_BITS-1:0]   err_shifted;
  logic signed [DIFF_BITS-1:0]     diff;
  logic signed [INTEGRAL_BITS:0]   acc_wide;
  logic signed [INTEGRAL_BITS-1:0] integral_sum;
  logic signed [INTEGRAL_BITS-1:0] integral_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    error       = $signed(ERR_BITS'(setpoint) - ERR_BITS'(sample));
    err_shifted = error[ERR_BITS-1:INT_SHIFT];
    diff        = $signed({error[ERR_BITS-1], error})
                - $signed({last_error[ERR_BITS-1], last_error});
    acc_wide    = $signed({integral_sum[INTEGRAL_BITS-1], integral_sum})
                + $signed({{(INTEGRAL_BITS+1-ERR_SH_BITS){err_shifted[ERR_SH_BITS-1]}},
                           err_shifted});
    if (acc_wide[INTEGRAL_BITS] != acc_wide[INTEGRAL_BITS-1]) begin
      integral_next = acc_wide[INTEGRAL_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      integral_next = acc_wide[INTEGRAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_error   <= '0;
      integral_sum <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        last_error   <= error;
        integral_sum <= integral_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.error    <= error;
      out_data.diff     <= diff;
      out_data.integral <= integral_next;
    end
  end

endmodule

### rtl/pid_mult_stage.sv
// Multiply stage: the three gain products, registered.
module pid_mult_stage import pid_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  err_t   in_data,
  input  gains_t gains,
  output logic   out_valid,
  input  logic   out_ready,
  output prod_t  out_data
);

  logic signed [P_BITS-1:0] p;
  logic signed [D_BITS-1:0] d;
  logic signed [I_BITS-1:0] i;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    p = $signed({1'b0, gains.kp}) * in_data.error;
    d = $signed({1'b0, gains.kd}) * in_data.diff;
    i = $signed({1'b0, gains.ki}) * in_data.integral;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.p <= p;
      out_data.d <= d;
      out_data.i <= i;
    end
  end

endmodule

### rtl/pid_out_stage.sv
// Output stages: sum, shift and clamp to drive, then servo position and result register.
module pid_out_stage import pid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  prod_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DRIVE_BITS-1:0] out_drive,
  output logic [SERVO_BITS-1:0] out_servo
);

  logic signed [SUM_BITS-1:0] sum;
  logic [DRIVE_BITS-1:0]      drive_next;
  logic [DRIVE_BITS-1:0]      drive;
  logic                       drive_valid;
  logic                       drive_ready;
  logic [QP_BITS-1:0]         quot_prod;
  logic [SERVO_BITS-1:0]      servo_next;

  assign drive_ready = !out_valid || out_ready;
  assign in_ready    = !drive_valid || drive_ready;

  always_comb begin
    sum = SUM_BITS'(in_data.p) + SUM_BITS'(in_data.d) + SUM_BITS'(in_data.i);
    if (sum[SUM_BITS-1]) begin
      drive_next = '0;
    end else if (|sum[SUM_BITS-2:DRIVE_BITS+OUT_SHIFT]) begin
      drive_next = DRIVE_MAX;
    end else begin
      drive_next = sum[DRIVE_BITS+OUT_SHIFT-1:OUT_SHIFT];
    end
  end

  always_comb begin
    quot_prod  = QP_BITS'(drive) * QP_BITS'(DIV_MUL);
    servo_next = SERVO_BASE + SERVO_BITS'(quot_prod[QP_BITS-1:DIV_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        drive_valid <= in_valid;
      end
      if (drive_ready) begin
        out_valid <= drive_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      drive <= drive_next;
    end
    if (drive_valid && drive_ready) begin
      out_drive <= drive;
      out_servo <= servo_next;
    end
  end

endmodule

### rtl/pid_servo_position_controller.sv
// Top level of the PID servo controller: config registers and the four-stage pipeline.
//
//  channel  | signals                                  | payload
//  ---------+------------------------------------------+------------------------------
//  input    | s_axis_tvalid/tready/tdata[15:0]         | sample[9:0]
//  output   | m_axis_tvalid/tready/tdata[23:0]         | drive[9:0], servo_position[17:10]
//  config   | wr_en, wr_index[1:0], wr_data[11:0]      | setpoint, kp, kd, ki
//
// One sample per cycle sustained while m_axis_tready holds; after its input transfer a result
// passes the error/integral stage (loaded at the transfer edge), then the multiply stage,
// the sum and clamp stage and the result register.
// rst is synchronous: clears the pipeline, previous error, integral and the config registers.
// A stalled output holds the result; the pipeline keeps filling until all four
// stages are full, and loop state advances on each input transfer.
module pid_servo_position_controller import pid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [15:0]              s_axis_tdata,   // [9:0] sample
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [9:0] drive, [17:10] servo_position
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data
);

  logic [SETPOINT_BITS-1:0] setpoint;
  gains_t                   gains;

  logic                  err_valid;
  logic                  err_ready;
  err_t                  err_data;
  logic                  prod_valid;
  logic                  prod_ready;
  prod_t                 prod_data;
  logic [DRIVE_BITS-1:0] drive;
  logic [SERVO_BITS-1:0] servo_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      gains    <= '0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_SETPOINT: setpoint <= wr_data[SETPOINT_BITS-1:0];
        REG_KP:       gains.kp <= wr_data[GAIN_BITS-1:0];
        REG_KD:       gains.kd <= wr_data[GAIN_BITS-1:0];
        REG_KI:       gains.ki <= wr_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  pid_err_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .setpoint  (setpoint),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_data  (err_data)
  );

  pid_mult_stage u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .gains     (gains),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  pid_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_drive (drive),
    .out_servo (servo_position)
  );

  assign m_axis_tdata = {6'd0, servo_position, drive};

endmodule

### rtl/pid_checker.sv
// Port-level checker for the PID servo controller, bound to the top level.
module pid_checker import pid_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [7:0]  servo_off;
  logic [11:0] servo_x10;

  assign servo_off = m_axis_tdata[17:10] - SERVO_BASE;
  assign servo_x10 = 12'(servo_off) * 12'd10;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_servo_rel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[17:10] >= SERVO_BASE
      && servo_x10 <= 12'(m_axis_tdata[9:0])
      && 12'(m_axis_tdata[9:0]) < servo_x10 + 12'd10)
    else $error("servo position does not match drive");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output side can move");

endmodule

bind pid_servo_position_controller pid_checker u_pid_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PID servo position controller.
module testbench;
  import pid_pkg::*;

  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam longint INTEG_MIN   = -(longint'(1) <<< (INTEGRAL_BITS - 1));
  localparam longint INTEG_MAX   = -INTEG_MIN - 1;

  typedef struct packed {
    logic [SERVO_BITS-1:0] servo_position;
    logic [DRIVE_BITS-1:0] drive;
  } servo_cmd_t;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [15:0]              s_axis_tdata;   // [9:0] sample
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [23:0]              m_axis_tdata;   // [9:0] drive, [17:10] servo_position
  logic                     wr_en;
  logic [CFG_IDX_BITS-1:0]  wr_index;
  logic [CFG_DATA_BITS-1:0] wr_data;

  // controller state as the testbench tracks it
  logic [SETPOINT_BITS-1:0] setpoint;
  logic [GAIN_BITS-1:0]     kp;
  logic [GAIN_BITS-1:0]     kd;
  logic [GAIN_BITS-1:0]     ki;
  longint                   prev_error;
  longint                   integral;

  servo_cmd_t awaited_cmds[$];

  int  cycles;
  int  n_samples;
  int  n_writes;
  int  n_checked;
  int  n_fail;
  int  hold_off;
  bit  sender_idles;
  bit  receiver_idles;

  pid_servo_position_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycles,
               awaited_cmds.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // One control tick: updates loop state and returns the expected output.
  function automatic servo_cmd_t pid_step(logic [SAMPLE_BITS-1:0] sample);
    longint     err;
    longint     acc;
    longint     y;
    longint     drv;
    servo_cmd_t cmd;
    err = longint'(setpoint) - longint'(sample);
    acc = integral + (err >>> INT_SHIFT);
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integral = acc;
    y = err * longint'(kp) + (err - prev_error) * longint'(kd) + longint'(ki) * acc;
    prev_error = err;
    if (y < 0) begin
      drv = 0;
    end else begin
      drv = y >>> OUT_SHIFT;
      if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);
    end
    cmd.drive = drv[DRIVE_BITS-1:0];
    cmd.servo_position = SERVO_BITS'(longint'(SERVO_BASE) + drv / 10);
    return cmd;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
    wr_index <= CFG_IDX_BITS'($urandom);
    wr_data  <= CFG_DATA_BITS'($urandom);
    case (idx)
      REG_SETPOINT: setpoint = data[SETPOINT_BITS-1:0];
      REG_KP:       kp = data;
      REG_KD:       kd = data;
      REG_KI:       ki = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_gains(logic [CFG_DATA_BITS-1:0] sp, logic [GAIN_BITS-1:0] p,
                           logic [GAIN_BITS-1:0] d, logic [GAIN_BITS-1:0] i);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_KP, p);
    write_reg(REG_KD, d);
    write_reg(REG_KI, i);
  endtask

  // Upper tdata bits are don't-care and get random values.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] sample);
    logic [15:0] word;
    int          gap;
    word = 16'($urandom);
    word[SAMPLE_BITS-1:0] = sample;
    if (sender_idles && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 2);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    awaited_cmds.push_back(pid_step(sample));
    n_samples++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver side: random stalls, or a counted hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else begin
        m_axis_tready <= !(receiver_idles && $urandom_range(99) < 22);
      end
    end
  end

  always @(posedge clk) begin : check_results
    servo_cmd_t got;
    servo_cmd_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[DRIVE_BITS+SERVO_BITS-1:0];
      if (awaited_cmds.size() == 0) begin
        n_fail++;
        if (n_fail <= 20) $error("result transfer with nothing awaited: %h", got);
      end else begin
        want = awaited_cmds.pop_front();
        n_checked++;
        if (got.drive !== want.drive) begin
          n_fail++;
          if (n_fail <= 20)
            $error("drive: expected %0d, got %0d", want.drive, got.drive);
        end
        if (got.servo_position !== want.servo_position) begin
          n_fail++;
          if (n_fail <= 20)
            $error("servo_position: expected %0d, got %0d", want.servo_position,
                   got.servo_position);
        end
      end
    end
  end

  // previous error starts at zero, so the first derivative term sees the whole error
  task automatic test_first_step();
    set_gains(12'hE00, 12'd1, 12'd3, 12'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd0);
    wait_idle();
  endtask

  task automatic test_extremes();
    set_gains(12'hFFF, 12'd4095, 12'd0, 12'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    wait_idle();
    write_reg(REG_KP, 12'd4);
    send_sample(10'd4);
    send_sample(10'd1020);
    send_sample(10'd1013);
    send_sample(10'd1014);
    wait_idle();
    set_gains(12'h000, 12'd1, 12'd0, 12'd0);
    send_sample(10'd1023);
    send_sample(10'd0);
    wait_idle();
    write_reg(REG_SETPOINT, 12'd3);
    send_sample(10'd0);
    wait_idle();
    write_reg(REG_SETPOINT, 12'd4);
    send_sample(10'd0);
    wait_idle();
    set_gains(12'h155, 12'd0, 12'd4095, 12'd4095);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'h2AA);
    wait_idle();
    set_gains(12'h3FF, 12'd0, 12'd0, 12'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    wait_idle();
  endtask

  task automatic test_output_stall();
    set_gains(12'd600, 12'd2, 12'd1, 12'd0);
    sender_idles = 1'b0;
    hold_off = 300;
    repeat (40) send_sample(SAMPLE_BITS'($urandom));
    wait_idle();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_loop();
    int s;
    for (int phase = 0; phase < 6; phase++) begin
      sender_idles   = (phase != 2);
      receiver_idles = (phase != 2);
      write_reg(REG_SETPOINT, CFG_DATA_BITS'($urandom));
      write_reg(REG_KP, ($urandom_range(3) == 0) ? GAIN_BITS'($urandom)
                                                 : GAIN_BITS'($urandom_range(15)));
      write_reg(REG_KD, ($urandom_range(3) == 0) ? GAIN_BITS'($urandom)
                                                 : GAIN_BITS'($urandom_range(15)));
      write_reg(REG_KI, ($urandom_range(3) == 0) ? GAIN_BITS'($urandom)
                                                 : GAIN_BITS'($urandom_range(2)));
      repeat (130) begin
        if ($urandom_range(9) < 7) begin
          // samples tracking within 64 of the setpoint, clipped to the sample range
          s = int'(setpoint) + int'($urandom_range(128)) - 64;
          if (s < 0) s = 0;
          if (s > 1023) s = 1023;
          send_sample(SAMPLE_BITS'(s));
        end else begin
          send_sample(SAMPLE_BITS'($urandom));
        end
      end
      wait_idle();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // pushes the integral deep negative under full integral gain, then pulls it back
  task automatic test_integral_floor();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_gains(12'd0, 12'd0, 12'd0, 12'd4095);
    repeat (48) send_sample(10'd1023);
    wait_idle();
    set_gains(12'd1023, 12'd4095, 12'd7, 12'd1);
    repeat (32) send_sample(SAMPLE_BITS'($urandom_range(7)));
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    setpoint = '0;
    kp = '0;
    kd = '0;
    ki = '0;
    prev_error = 0;
    integral = 0;
    cycles = 0;
    n_samples = 0;
    n_writes = 0;
    n_checked = 0;
    n_fail = 0;
    hold_off = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_step();
    test_extremes();
    test_output_stall();
    test_random_loop();
    test_integral_floor();

    $display("Checked %0d results from %0d sample transfers over %0d register writes.",
             n_checked, n_samples, n_writes);
    $display("Included gain and setpoint extremes, a 300-cycle output stall %s",
             "and a deeply negative integral under full gain.");
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/pid_pkg.sv
rtl/pid_err_stage.sv
rtl/pid_mult_stage.sv
rtl/pid_out_stage.sv
rtl/pid_servo_position_controller.sv
rtl/pid_checker.sv
verif/testbench.sv
